### src/swfp_pkg.sv
`timescale 1ns / 1ps
// Package for the sync word frame parser.
// Holds the sync byte values, hunt and frame positions, and the result type.
package swfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;

   localparam int unsigned POS_W = 4;

   // Sync progress codes while hunting.
   localparam logic [POS_W-1:0] HUNT_IDLE     = 4'd0;
   localparam logic [POS_W-1:0] HUNT_GOT_55   = 4'd1;
   localparam logic [POS_W-1:0] HUNT_GOT_PAIR = 4'd2;
   localparam logic [POS_W-1:0] HUNT_GOT_55B  = 4'd3;

   // Byte positions of the high bytes of the kept words inside a frame.
   localparam logic [POS_W-1:0] POS_X_HI      = 4'd5;
   localparam logic [POS_W-1:0] POS_Y_HI      = 4'd7;
   localparam logic [POS_W-1:0] POS_WIDTH_HI  = 4'd9;
   localparam logic [POS_W-1:0] POS_HEIGHT_HI = 4'd11;

   typedef struct packed {
      logic [15:0] obj_x;
      logic [15:0] obj_y;
      logic [15:0] obj_width;
      logic [15:0] obj_height;
   } obj_type;

endpackage

### src/swfp_parse.sv
`timescale 1ns / 1ps
// Parser core: sync hunt, frame byte counter and word assembly.
// Depends on swfp_pkg.
module swfp_parse
   import swfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  rx_byte,
   output logic        emit,
   output obj_type     obj
);

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       low_ff, low_in;
   logic [15:0]      held_x_ff, held_x_in;
   logic [15:0]      held_y_ff, held_y_in;
   logic [15:0]      held_w_ff, held_w_in;
   logic [15:0]      word;

   assign word = {rx_byte, low_ff};
   assign emit = in_frame_ff && (pos_ff == POS_HEIGHT_HI);

   assign obj.obj_x      = held_x_ff;
   assign obj.obj_y      = held_y_ff;
   assign obj.obj_width  = held_w_ff;
   assign obj.obj_height = word;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      low_in      = low_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      held_w_in   = held_w_ff;
      if (!in_frame_ff) begin
         case (pos_ff)
            HUNT_IDLE: begin
               pos_in = (rx_byte == SYNC_FIRST) ? HUNT_GOT_55 : HUNT_IDLE;
            end
            HUNT_GOT_55: begin
               pos_in = (rx_byte == SYNC_SECOND) ? HUNT_GOT_PAIR : HUNT_IDLE;
            end
            HUNT_GOT_PAIR: begin
               if (rx_byte == SYNC_FIRST) begin
                  pos_in = HUNT_GOT_55B;
               end else begin
                  // This byte is already the checksum low byte.
                  low_in      = rx_byte;
                  pos_in      = 4'd1;
                  in_frame_in = 1'b1;
               end
            end
            HUNT_GOT_55B: begin
               pos_in      = HUNT_IDLE;
               in_frame_in = (rx_byte == SYNC_SECOND);
            end
            default: begin
               pos_in = HUNT_IDLE;
            end
         endcase
      end else if (pos_ff[0]) begin
         pos_in = pos_ff + 4'd1;
         case (pos_ff)
            POS_X_HI:     held_x_in = word;
            POS_Y_HI:     held_y_in = word;
            POS_WIDTH_HI: held_w_in = word;
            POS_HEIGHT_HI: begin
               in_frame_in = 1'b0;
               pos_in      = HUNT_IDLE;
            end
            default: begin
               // Checksum and signature words are dropped.
            end
         endcase
      end else begin
         low_in = rx_byte;
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= HUNT_IDLE;
      end else if (fire) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         low_ff    <= low_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_w_ff <= held_w_in;
      end
   end

endmodule

### src/swfp_out.sv
`timescale 1ns / 1ps
// Result register with valid/stall handshake toward the consumer.
// Depends on swfp_pkg.
module swfp_out
   import swfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  obj_type load_obj,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output obj_type rsp_obj
);

   logic    valid_ff, valid_in;
   obj_type obj_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_obj   = obj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         obj_ff <= load_obj;
      end
   end

endmodule

### src/sync_word_frame_parser.sv
`timescale 1ns / 1ps
// Sync word frame parser, top level. rsp_valid rises once the item carrying the
// height high byte has been accepted, has waited in the input register and has
// loaded the result register. Throughput: one item per cycle; the only stall
// comes from a result held by rsp_stall. Synchronous active-high reset returns
// the parser to sync hunting and empties the input and result registers.
module sync_word_frame_parser
   import swfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_obj_x,
   output logic [15:0] rsp_obj_y,
   output logic [15:0] rsp_obj_width,
   output logic [15:0] rsp_obj_height
);

   // Input register: one received byte waits here for the parser.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;

   logic       fire;
   logic       emit;
   logic       out_free;
   obj_type    obj;
   obj_type    rsp_obj;

   // The held byte is consumed unless it completes a frame while the result
   // register is still occupied by a result that the consumer has not taken.
   assign fire      = in_vld_ff && (!emit || out_free);
   assign req_stall = in_vld_ff && !fire;
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   swfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .obj     (obj)
   );

   swfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .load_obj  (obj),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_obj   (rsp_obj)
   );

   assign rsp_obj_x      = rsp_obj.obj_x;
   assign rsp_obj_y      = rsp_obj.obj_y;
   assign rsp_obj_width  = rsp_obj.obj_width;
   assign rsp_obj_height = rsp_obj.obj_height;

endmodule
